@@ rtl/text_console_char_engine_macros.svh @@
// ----------------------------------------------------------------------------
// Text console character engine assertion macros
// Short forms for the concurrent checks used inside the engine. Each macro
// samples on the rising edge of clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCCE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCCE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tcce_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console character engine package
// Geometry, field widths, character codes, state type and the tab table.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // Screen geometry.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_WIDTH  = 8;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_COUNT = CELL_COUNT - COLUMNS;

  // Field widths of the channels.
  localparam int REQ_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 4;
  localparam int ADDR_IN_W = 11;
  localparam int LOC_W     = 11;
  localparam int CELL_W    = 16;

  // Internal widths derived from the geometry.
  localparam int ADDR_W  = $clog2(CELL_COUNT);
  localparam int LIN_W   = $clog2(CELL_COUNT + 1);
  localparam int CMP_W   = (LIN_W > ADDR_IN_W) ? LIN_W : ADDR_IN_W;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int NCOL_W  = $clog2(COLUMNS + TAB_WIDTH);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int NROW_W  = $clog2(ROWS + 1);

  // Request types.
  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Character codes with special handling.
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // A blank cell: white on black space.
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_BLANK,
    ST_EMIT
  } tcce_state_t;

  // Next tab stop for every column, built at elaboration.
  typedef logic [NCOL_W-1:0] tab_table_t [COLUMNS];

  function automatic tab_table_t build_tab_next();
    tab_table_t t;
    for (int i = 0; i < COLUMNS; i++) begin
      t[i] = NCOL_W'(i + TAB_WIDTH - (i % TAB_WIDTH));
    end
    return t;
  endfunction

  localparam tab_table_t TAB_NEXT = build_tab_next();

endpackage

@@ rtl/tcce_if.sv @@
// ----------------------------------------------------------------------------
// Text console character engine channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface tcce_in_if;
  logic                             valid;
  logic                             ready;
  logic [tcce_pkg::REQ_W-1:0]       req_type;
  logic [tcce_pkg::CHAR_W-1:0]      char_code;
  logic [tcce_pkg::COLOR_W-1:0]     bg_color;
  logic [tcce_pkg::COLOR_W-1:0]     fg_color;
  logic [tcce_pkg::ADDR_IN_W-1:0]   cell_address;

  modport source (
    output valid, req_type, char_code, bg_color, fg_color, cell_address,
    input  ready
  );
  modport sink (
    input  valid, req_type, char_code, bg_color, fg_color, cell_address,
    output ready
  );
endinterface

interface tcce_out_if;
  logic                          valid;
  logic                          ready;
  logic [tcce_pkg::LOC_W-1:0]    cursor_location;
  logic [tcce_pkg::CELL_W-1:0]   read_data;

  modport source (
    output valid, cursor_location, read_data,
    input  ready
  );
  modport sink (
    input  valid, cursor_location, read_data,
    output ready
  );
endinterface

@@ rtl/text_console_char_engine.sv @@
// ----------------------------------------------------------------------------
// Text console character engine
// Request items arrive on in_ch (put character, read cell, clear screen) and
// each yields one result item on out_ch: the linear cursor location after
// the request and, for reads, the cell contents (zero otherwise).
// From acceptance, a put without scrolling, a read past the end of the
// screen and an unused type go straight to the result state, which loads
// the output register; a read inside the screen passes the read state
// first. A put that scrolls copies COPY_COUNT cells one per cycle through
// the screen memory port, then blanks the last row; a clear blanks every
// cell. One item is worked on at a time: a new request is accepted only
// once the engine is back in idle. Reset starts a clearing pass that
// blanks the memory; in_ch.ready stays low until it ends, and no result
// is produced. The output register holds a result until it is taken. The
// next request is accepted while that result waits, but its own result is
// held back in the engine until the output register is free.
// ----------------------------------------------------------------------------
`include "text_console_char_engine_macros.svh"

module text_console_char_engine (
  input  logic         clk,
  input  logic         rst_n,
  tcce_in_if.sink      in_ch,
  tcce_out_if.source   out_ch
);
  import tcce_pkg::*;

  // Control state.
  tcce_state_t          state_r, state_nxt;
  logic [LIN_W-1:0]     cnt_r, cnt_nxt;       // sweep position in scroll/blank
  logic                 emit_r, emit_nxt;     // a sweep ends with a result
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic                 out_valid_r;

  // Payload registers.
  logic [CELL_W-1:0]    res_data_r, res_data_nxt;
  logic [LOC_W-1:0]     out_loc_r;
  logic [CELL_W-1:0]    out_data_r;
  logic                 out_load;

  // Screen memory: one write and one registered read per cycle.
  logic [CELL_W-1:0]    mem [CELL_COUNT];
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [CELL_W-1:0]    mem_wdata;
  logic [ADDR_W-1:0]    mem_raddr;
  logic [CELL_W-1:0]    mem_rdata_r;

  // Cursor arithmetic for a put request.
  logic [NCOL_W-1:0]    put_ncol;
  logic [NROW_W-1:0]    put_nrow;
  logic                 put_printable;
  logic                 put_scroll;
  logic [ADDR_W-1:0]    cur_pos;
  logic [CMP_W-1:0]     rd_addr_wide;
  logic                 rd_in_range;
  logic [CMP_W-1:0]     loc_wide;
  logic                 in_accept;

  assign in_accept = in_ch.valid && in_ch.ready;

  assign cur_pos = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);

  assign loc_wide = CMP_W'(LIN_W'(row_r) * LIN_W'(COLUMNS) + LIN_W'(col_r));

  assign rd_addr_wide = CMP_W'(in_ch.cell_address);
  assign rd_in_range  = rd_addr_wide < CMP_W'(CELL_COUNT);

  // Column and row after a put, before the scroll check.
  always_comb begin
    logic [NCOL_W-1:0] ncol;
    logic [NROW_W-1:0] nrow;
    ncol          = NCOL_W'(col_r);
    nrow          = NROW_W'(row_r);
    put_printable = 1'b0;
    if (in_ch.char_code == CH_BS) begin
      if (col_r != '0) begin
        ncol = NCOL_W'(col_r) - NCOL_W'(1);
      end
    end else if (in_ch.char_code == CH_TAB) begin
      ncol = TAB_NEXT[col_r];
    end else if (in_ch.char_code == CH_CR) begin
      ncol = '0;
    end else if (in_ch.char_code == CH_LF) begin
      ncol = '0;
      nrow = NROW_W'(row_r) + NROW_W'(1);
    end else if (in_ch.char_code >= CH_SPACE) begin
      put_printable = 1'b1;
      ncol          = NCOL_W'(col_r) + NCOL_W'(1);
    end
    // Line wrap.
    if (ncol >= NCOL_W'(COLUMNS)) begin
      ncol = '0;
      nrow = NROW_W'(row_r) + NROW_W'(1);
    end
    put_ncol   = ncol;
    put_nrow   = nrow;
    put_scroll = nrow >= NROW_W'(ROWS);
  end

  // Next state, memory port control and cursor updates.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    emit_nxt     = emit_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    res_data_nxt = res_data_r;
    mem_we       = 1'b0;
    mem_waddr    = cnt_r[ADDR_W-1:0];
    mem_wdata    = BLANK_CELL;
    mem_raddr    = cnt_r[ADDR_W-1:0] + ADDR_W'(COLUMNS);
    in_ch.ready  = 1'b0;
    out_load     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        mem_raddr   = rd_addr_wide[ADDR_W-1:0];
        if (in_ch.valid) begin
          res_data_nxt = '0;
          case (in_ch.req_type)
            REQ_PUT: begin
              col_nxt = put_ncol[COL_W-1:0];
              if (put_printable) begin
                mem_we    = 1'b1;
                mem_waddr = cur_pos;
                mem_wdata = {in_ch.bg_color, in_ch.fg_color, in_ch.char_code};
              end
              if (put_scroll) begin
                row_nxt   = ROW_W'(ROWS - 1);
                cnt_nxt   = '0;
                state_nxt = ST_SCROLL;
              end else begin
                row_nxt   = put_nrow[ROW_W-1:0];
                state_nxt = ST_EMIT;
              end
            end
            REQ_READ: begin
              state_nxt = rd_in_range ? ST_READ : ST_EMIT;
            end
            REQ_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              cnt_nxt   = '0;
              emit_nxt  = 1'b1;
              state_nxt = ST_BLANK;
            end
            default: begin
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end

      ST_READ: begin
        res_data_nxt = mem_rdata_r;
        state_nxt    = ST_EMIT;
      end

      // Row shift: read cell cnt+COLUMNS, write it to cnt-1 in the following cycle.
      ST_SCROLL: begin
        if (cnt_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r[ADDR_W-1:0] - ADDR_W'(1);
          mem_wdata = mem_rdata_r;
        end
        if (cnt_r == LIN_W'(COPY_COUNT)) begin
          emit_nxt  = 1'b1;
          state_nxt = ST_BLANK;
        end else begin
          cnt_nxt = cnt_r + LIN_W'(1);
        end
      end

      // Blank cells from cnt to the end: the last row after a scroll, or
      // the whole screen after a clear request or reset.
      ST_BLANK: begin
        mem_we = 1'b1;
        if (cnt_r == LIN_W'(CELL_COUNT - 1)) begin
          state_nxt = emit_r ? ST_EMIT : ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + LIN_W'(1);
        end
      end

      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_BLANK;
      cnt_r       <= '0;
      emit_r      <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      emit_r  <= (state_nxt == ST_BLANK) ? emit_nxt : 1'b0;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_data_r <= res_data_nxt;
    if (out_load) begin
      out_loc_r  <= loc_wide[LOC_W-1:0];
      out_data_r <= res_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.cursor_location = out_loc_r;
  assign out_ch.read_data       = out_data_r;

  // Checks.
  `TCCE_ASSERT_NOW(a_cursor_in_range, state_r == ST_IDLE,
    (NCOL_W'(col_r) < NCOL_W'(COLUMNS)) && (NROW_W'(row_r) < NROW_W'(ROWS)),
    "cursor outside the screen while idle")
  `TCCE_ASSERT_NOW(a_write_in_range, mem_we,
    LIN_W'(mem_waddr) < LIN_W'(CELL_COUNT),
    "screen memory write beyond the last cell")
  `TCCE_ASSERT_NXT(a_read_follows_request, in_accept && in_ch.req_type == REQ_READ,
    state_r == ST_READ || state_r == ST_EMIT,
    "read request did not go to the read or result state")
  `TCCE_ASSERT_NXT(a_clear_homes_cursor, in_accept && in_ch.req_type == REQ_CLEAR,
    state_r == ST_BLANK && cnt_r == '0 && col_r == '0 && row_r == '0 && emit_r,
    "clear request did not start a full blanking pass")
  `TCCE_ASSERT_NOW(a_load_only_when_free, out_load,
    state_r == ST_EMIT && (!out_valid_r || out_ch.ready),
    "output register loaded while an untaken result is held")

endmodule
